>>> rtl/h2fd_pkg.sv
package h2fd_pkg;

  localparam int HeaderBytes  = 9;
  localparam int PrefaceBytes = 24;

  localparam logic [2:0] ROLE_PREFACE = 3'd0;
  localparam logic [2:0] ROLE_HEADER  = 3'd1;
  localparam logic [2:0] ROLE_PADLEN  = 3'd2;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
  localparam logic [2:0] ROLE_PADDING = 3'd4;
  localparam logic [2:0] ROLE_IGNORED = 3'd5;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_PREFACE    = 3'd1;
  localparam logic [2:0] ERR_MISS_CONT  = 3'd2;
  localparam logic [2:0] ERR_UNEXP_CONT = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd4;
  localparam logic [2:0] ERR_PAD_EMPTY  = 3'd5;
  localparam logic [2:0] ERR_PAD_LONG   = 3'd6;

  localparam logic [7:0] T_DATA    = 8'd0;
  localparam logic [7:0] T_HEADERS = 8'd1;
  localparam logic [7:0] T_PUSH    = 8'd5;
  localparam logic [7:0] T_CONT    = 8'd9;
  localparam int F_END_HEADERS = 2;
  localparam int F_PADDED      = 3;

  localparam logic [0:0] CFG_EXPECT_PREFACE = 1'b0;
  localparam logic [0:0] CFG_MAX_NONDATA    = 1'b1;

  typedef struct packed {
    logic [2:0]  role;
    logic        frame_end;
    logic        flush_point;
    logic [7:0]  frame_kind;
    logic [30:0] stream_number;
    logic [23:0] payload_length;
    logic        flag_warning;
    logic [2:0]  error_code;
  } h2fd_result_t;

  localparam int ResultBits = $bits(h2fd_result_t);

  function automatic logic [7:0] preface_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0: c = 8'h50;   5'd1: c = 8'h52;   5'd2: c = 8'h49;   5'd3: c = 8'h20;
      5'd4: c = 8'h2A;   5'd5: c = 8'h20;   5'd6: c = 8'h48;   5'd7: c = 8'h54;
      5'd8: c = 8'h54;   5'd9: c = 8'h50;   5'd10: c = 8'h2F;  5'd11: c = 8'h32;
      5'd12: c = 8'h2E;  5'd13: c = 8'h30;  5'd14: c = 8'h0D;  5'd15: c = 8'h0A;
      5'd16: c = 8'h0D;  5'd17: c = 8'h0A;  5'd18: c = 8'h53;  5'd19: c = 8'h4D;
      5'd20: c = 8'h0D;  5'd21: c = 8'h0A;  5'd22: c = 8'h0D;  5'd23: c = 8'h0A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/http2_frame_delineator.sv
// HTTP/2 frame delineator: one byte in, one result item out per byte.
// A result item is formed combinationally and written into the result queue when its byte is accepted.
// Throughput: one byte per cycle, sustained while the result side takes items;
// a two-entry result queue absorbs stalls so intake stops only when it is full.
// Reset (rst, synchronous): clears parser state and the queue; registers
// return to expect_preface = 1 and max_nondata_octets = 63780.
module http2_frame_delineator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [24:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] byte_role, [3] frame_end, [4] flush_point, [12:5] frame_kind,
  // [43:13] stream_number, [67:44] payload_length, [68] flag_warning,
  // [71:69] error_code
  output logic [71:0] m_tdata
);
  import h2fd_pkg::*;

  logic         expect_preface;
  logic [24:0]  max_nondata;
  logic         step;
  h2fd_result_t res, q_out;

  // configuration registers: to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_preface <= 1'b1;
      max_nondata    <= 25'd63780;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECT_PREFACE: expect_preface <= cfg_wdata[0];
        CFG_MAX_NONDATA:    max_nondata    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: classify each byte as it is accepted
  assign step = s_tvalid && s_tready;

  h2fd_parser u_parser (
    .clk, .rst,
    .cfg_expect_preface(expect_preface),
    .cfg_max_nondata(max_nondata),
    .step, .data_byte(s_tdata),
    .result(res)
  );

  // back: queue result items towards the master side
  h2fd_out_queue u_queue (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(res),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(q_out)
  );

  assign m_tdata = {q_out.error_code, q_out.flag_warning, q_out.payload_length,
                    q_out.stream_number, q_out.frame_kind, q_out.flush_point,
                    q_out.frame_end, q_out.role};
endmodule

>>> rtl/h2fd_parser.sv
module h2fd_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_expect_preface,
  input  logic [24:0]           cfg_max_nondata,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  output h2fd_pkg::h2fd_result_t result
);
  import h2fd_pkg::*;

  typedef enum logic [2:0] {
    PH_START, PH_PREFACE, PH_HEADER, PH_PADLEN, PH_BODY
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  preface_count, preface_count_next;
  logic [3:0]  header_count, header_count_next;
  logic [7:0]  hdr [0:7];
  logic [23:0] octets_left, octets_left_next;
  logic [7:0]  padding_left, padding_left_next;
  logic [7:0]  lead_type, lead_type_next;
  logic [30:0] lead_stream, lead_stream_next;
  logic [25:0] block_length, block_length_next;
  logic        cont_wanted, cont_wanted_next;
  logic        aborted, aborted_next;
  logic [2:0]  err, err_next;
  logic [23:0] frame_len, frame_len_next;
  h2fd_result_t res;

  phase_t      ph;
  logic [23:0] len;
  logic [7:0]  typ, flg;
  logic [30:0] sid;
  logic [24:0] len9;
  logic [25:0] blk_sum;
  logic [23:0] ol_dec;
  logic        is_hdrs;

  always_comb begin
    ph = phase;
    if (ph == PH_START) ph = cfg_expect_preface ? PH_PREFACE : PH_HEADER;
    phase_next = ph;
    preface_count_next = preface_count;
    header_count_next = header_count;
    octets_left_next = octets_left;
    padding_left_next = padding_left;
    lead_type_next = lead_type;
    lead_stream_next = lead_stream;
    block_length_next = block_length;
    cont_wanted_next = cont_wanted;
    aborted_next = aborted;
    err_next = err;
    frame_len_next = frame_len;
    res = '0;
    res.role = ROLE_IGNORED;
    len = {hdr[0], hdr[1], hdr[2]};
    typ = hdr[3];
    flg = hdr[4];
    sid = {hdr[5][6:0], hdr[6], hdr[7], data_byte};
    len9 = {1'b0, len} + 25'd9;
    blk_sum = block_length + {1'b0, len9};
    ol_dec = (octets_left != '0) ? octets_left - 24'd1 : octets_left;
    is_hdrs = (typ == T_HEADERS) || (typ == T_PUSH);

    if (!aborted) begin
      unique case (ph)
        PH_PREFACE: begin
          res.role = ROLE_PREFACE;
          if (preface_count >= 5'(PrefaceBytes) || data_byte != preface_char(preface_count))
          begin
            aborted_next = 1'b1; err_next = ERR_PREFACE;
          end else begin
            preface_count_next = preface_count + 5'd1;
            if (preface_count == 5'(PrefaceBytes - 1)) begin
              res.flush_point = 1'b1;
              phase_next = PH_HEADER;
            end
          end
        end
        PH_HEADER: begin
          res.role = ROLE_HEADER;
          header_count_next = header_count + 4'd1;
          if (header_count == 4'(HeaderBytes - 1)) begin
            frame_len_next = len;
            if (cont_wanted && (typ != T_CONT || sid != lead_stream)) begin
              aborted_next = 1'b1; err_next = ERR_MISS_CONT;
            end else if (typ == T_CONT && !cont_wanted) begin
              aborted_next = 1'b1; err_next = ERR_UNEXP_CONT;
            end else begin
              if (typ != T_CONT) begin
                lead_type_next = typ;
                lead_stream_next = sid;
              end
              if (is_hdrs && !flg[F_END_HEADERS]) block_length_next = {1'b0, len9};
              if (typ == T_CONT) begin
                res.flag_warning = (flg & ~8'h04) != 8'h00;
                block_length_next = blk_sum;
              end
              if ((typ == T_CONT && blk_sum > {1'b0, cfg_max_nondata}) ||
                  (typ != T_DATA && len9 > cfg_max_nondata)) begin
                aborted_next = 1'b1; err_next = ERR_TOO_LONG;
              end else begin
                octets_left_next = len;
                padding_left_next = '0;
                if (flg[F_PADDED] && (typ == T_DATA || is_hdrs)) begin
                  if (len == '0) begin
                    aborted_next = 1'b1; err_next = ERR_PAD_EMPTY;
                  end else phase_next = PH_PADLEN;
                end else if (len == '0) begin
                  res.frame_end = 1'b1;
                  cont_wanted_next = (is_hdrs || typ == T_CONT) && !flg[F_END_HEADERS];
                  res.flush_point = !cont_wanted_next;
                  header_count_next = '0;
                end else phase_next = PH_BODY;
              end
            end
          end
        end
        PH_PADLEN: begin
          res.role = ROLE_PADLEN;
          octets_left_next = ol_dec;
          if (frame_len == '0 || {16'd0, data_byte} > frame_len - 24'd1) begin
            aborted_next = 1'b1; err_next = ERR_PAD_LONG;
          end else begin
            padding_left_next = data_byte;
            if (ol_dec == '0) begin
              res.frame_end = 1'b1;
              cont_wanted_next = (hdr[3] == T_HEADERS || hdr[3] == T_PUSH ||
                                  hdr[3] == T_CONT) && !hdr[4][F_END_HEADERS];
              res.flush_point = !cont_wanted_next;
              header_count_next = '0; octets_left_next = '0; padding_left_next = '0;
              phase_next = PH_HEADER;
            end else phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          res.role = (octets_left <= {16'd0, padding_left}) ? ROLE_PADDING : ROLE_PAYLOAD;
          octets_left_next = ol_dec;
          if (ol_dec == '0) begin
            res.frame_end = 1'b1;
            cont_wanted_next = (hdr[3] == T_HEADERS || hdr[3] == T_PUSH ||
                                hdr[3] == T_CONT) && !hdr[4][F_END_HEADERS];
            res.flush_point = !cont_wanted_next;
            header_count_next = '0; padding_left_next = '0;
            phase_next = PH_HEADER;
          end
        end
        default: ;
      endcase
      if (aborted_next) begin
        res.frame_end = 1'b0;
        res.flush_point = 1'b0;
      end
    end
    res.frame_kind = lead_type_next;
    res.stream_number = lead_stream_next;
    res.payload_length = frame_len_next;
    res.error_code = err_next;
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      preface_count <= '0; header_count <= '0;
      octets_left <= '0; padding_left <= '0;
      lead_type <= '0; lead_stream <= '0; block_length <= '0;
      cont_wanted <= 1'b0; aborted <= 1'b0; err <= ERR_NONE; frame_len <= '0;
    end else if (step) begin
      phase <= phase_next;
      preface_count <= preface_count_next; header_count <= header_count_next;
      octets_left <= octets_left_next; padding_left <= padding_left_next;
      lead_type <= lead_type_next; lead_stream <= lead_stream_next;
      block_length <= block_length_next; cont_wanted <= cont_wanted_next;
      aborted <= aborted_next; err <= err_next; frame_len <= frame_len_next;
    end
  end

  // hold header bytes by position; the last one is used straight from the input
  always_ff @(posedge clk) begin
    if (step && !aborted && ph == PH_HEADER && header_count < 4'(HeaderBytes - 1))
      hdr[header_count[2:0]] <= data_byte;
  end

  assert property (@(posedge clk) disable iff (rst)
    aborted |=> aborted) else $error("abort not sticky");
  assert property (@(posedge clk) disable iff (rst)
    (step && aborted) |-> (res.role == ROLE_IGNORED && !res.frame_end))
    else $error("byte after abort not ignored");
  assert property (@(posedge clk) disable iff (rst)
    res.flush_point |-> (res.frame_end || res.role == ROLE_PREFACE))
    else $error("flush without unit end");
endmodule

>>> rtl/h2fd_out_queue.sv
module h2fd_out_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  h2fd_pkg::h2fd_result_t in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output h2fd_pkg::h2fd_result_t out_data
);
  import h2fd_pkg::*;

  h2fd_result_t mem [0:1];
  logic [1:0] count;
  logic       wr_ptr, rd_ptr;
  logic       push, pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; wr_ptr <= 1'b0; rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1) else $error("count slip");
  assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 2'd1) else $error("count slip");
endmodule
